// ===== hdl/i2p_pkg.sv =====
// shared types, codes and helper functions for the infix to postfix converter
package i2p_pkg;

   localparam int STACK_DEPTH_DEFAULT = 32;
   localparam int COUNT_W = 6;
   localparam int CODE_W = 3;
   localparam int SYM_W = 8;
   localparam int STATUS_W = 2;

   localparam logic [CODE_W-1:0] CODE_LPAREN = 3'd0;
   localparam logic [CODE_W-1:0] CODE_PLUS = 3'd1;
   localparam logic [CODE_W-1:0] CODE_MINUS = 3'd2;
   localparam logic [CODE_W-1:0] CODE_MUL = 3'd3;
   localparam logic [CODE_W-1:0] CODE_DIV = 3'd4;
   localparam logic [CODE_W-1:0] CODE_POW = 3'd5;
   localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;

   localparam logic [SYM_W-1:0] CHAR_LPAREN = 8'h28;
   localparam logic [SYM_W-1:0] CHAR_RPAREN = 8'h29;
   localparam logic [SYM_W-1:0] CHAR_POW = 8'h5E;
   localparam logic [SYM_W-1:0] CHAR_PLUS = 8'h2B;
   localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [SYM_W-1:0] CHAR_MUL = 8'h2A;
   localparam logic [SYM_W-1:0] CHAR_DIV = 8'h2F;
   localparam logic [SYM_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [SYM_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [SYM_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [SYM_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [SYM_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [SYM_W-1:0] CHAR_NINE = 8'h39;
   localparam logic [SYM_W-1:0] CHAR_NUL = 8'h00;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNMATCHED = 2'd2;

   typedef struct packed {
      logic command;
      logic [SYM_W-1:0] symbol;
   } req_payload_type;

   typedef struct packed {
      logic [SYM_W-1:0] out_symbol;
      logic symbol_valid;
      logic last_of_run;
      logic expression_done;
      logic [STATUS_W-1:0] status;
   } rsp_payload_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
      logic [CODE_W-1:0] code;
   } stk_cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [CODE_W-1:0] top;
      logic [CODE_W-1:0] next;
   } stk_status_type;

   function automatic logic [SYM_W-1:0] code_char(input logic [CODE_W-1:0] code);
      logic [SYM_W-1:0] c;
      unique case (code)
         CODE_LPAREN: c = CHAR_LPAREN;
         CODE_PLUS:   c = CHAR_PLUS;
         CODE_MINUS:  c = CHAR_MINUS;
         CODE_MUL:    c = CHAR_MUL;
         CODE_DIV:    c = CHAR_DIV;
         CODE_POW:    c = CHAR_POW;
         default:     c = CHAR_NUL;
      endcase
      return c;
   endfunction

   function automatic logic [1:0] code_prec(input logic [CODE_W-1:0] code);
      logic [1:0] p;
      unique case (code)
         CODE_PLUS, CODE_MINUS: p = 2'd1;
         CODE_MUL, CODE_DIV:    p = 2'd2;
         CODE_POW:              p = 2'd3;
         default:               p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic logic [CODE_W-1:0] op_code(input logic [SYM_W-1:0] c);
      logic [CODE_W-1:0] code;
      unique case (c)
         CHAR_PLUS:  code = CODE_PLUS;
         CHAR_MINUS: code = CODE_MINUS;
         CHAR_MUL:   code = CODE_MUL;
         CHAR_DIV:   code = CODE_DIV;
         CHAR_POW:   code = CODE_POW;
         default:    code = CODE_NONE;
      endcase
      return code;
   endfunction

   function automatic logic is_operand(input logic [SYM_W-1:0] c);
      return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
             (c >= CHAR_ZERO && c <= CHAR_NINE);
   endfunction

   // true when the stacked operator leaves before the incoming one is pushed
   function automatic logic pops_before(input logic [CODE_W-1:0] incoming,
                                        input logic [CODE_W-1:0] stacked);
      logic [1:0] p;
      logic [1:0] tp;
      p = code_prec(incoming);
      tp = code_prec(stacked);
      return (stacked != CODE_LPAREN) &&
             ((p < tp) || ((p == tp) && (incoming != CODE_POW)));
   endfunction

endpackage

// ===== hdl/i2p_if.sv =====
// valid/ready channel interfaces for the request and response sides
interface i2p_req_if;
   logic valid;
   logic ready;
   logic command;
   logic [7:0] symbol;

   modport source (output valid, output command, output symbol, input ready);
   modport sink (input valid, input command, input symbol, output ready);
endinterface

interface i2p_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] out_symbol;
   logic symbol_valid;
   logic last_of_run;
   logic expression_done;
   logic [1:0] status;

   modport source (output valid, output out_symbol, output symbol_valid,
                   output last_of_run, output expression_done, output status,
                   input ready);
   modport sink (input valid, input out_symbol, input symbol_valid,
                 input last_of_run, input expression_done, input status,
                 output ready);
endinterface

// ===== hdl/infix_to_postfix_converter.sv =====
// top level of the shunting-yard infix to postfix converter
//
// req_chan takes one infix character per transaction: command 0 processes
// symbol, command 1 ends the expression and flushes the operator stack.
// rsp_chan returns postfix characters one per transaction; last_of_run marks
// the final response caused by a request, and the end command closes with a
// done response carrying status (ok, stack overflow, unmatched ')').
// Operands are latched when accepted and sent from the EMIT state. '(' and
// ignored characters finish in the accepting cycle. An operator or ')' pops
// the stack, a single stack pop per cycle while the response register can
// take one, and then pushes the operator or drops the matching '('. The end
// command pops each stacked entry as a response, then sends the done
// response. req_chan.ready is high only while the sequencer is idle.
// The top stack entry and the one below it sit in registers, the rest in a
// memory with a registered read kept one entry ahead of the top.
// Responses sit in one output register; while rsp_chan stalls the sequencer
// waits at its next response with req_chan.ready low, though requests that
// cause no response are still taken while idle. Reset empties the stack,
// clears the sticky error and drops any pending response; no clearing pass
// is needed.
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   i2p_req_if.sink   req_chan,
   i2p_rsp_if.source rsp_chan
);
   import i2p_pkg::*;

   stk_cmd_type stk_cmd;
   stk_status_type stk_status;

   i2p_seq #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .stk_cmd(stk_cmd),
      .stk_status(stk_status)
   );

   i2p_stack #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock(clock),
      .reset(reset),
      .cmd(stk_cmd),
      .status(stk_status)
   );

endmodule

// ===== hdl/i2p_stack.sv =====
// operator stack: top entry in a register, the rest in a memory with a registered read
module i2p_stack #(
   parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  i2p_pkg::stk_cmd_type    cmd,
   output i2p_pkg::stk_status_type status
);
   import i2p_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);

   logic [CODE_W-1:0] mem [STACK_DEPTH];
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CODE_W-1:0] top_ff, top_in;
   logic [CODE_W-1:0] next_ff;
   logic wr_en;
   logic [ADDR_W-1:0] wr_ptr;
   logic [ADDR_W-1:0] rd_ptr;
   logic [COUNT_W-1:0] wr_sum;
   logic [COUNT_W-1:0] rd_sum;

   always_comb begin
      count_in = count_ff;
      top_in = top_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.push) begin
         count_in = count_ff + COUNT_W'(1);
         top_in = cmd.code;
      end else if (cmd.pop) begin
         count_in = count_ff - COUNT_W'(1);
         top_in = next_ff;
      end
   end

   // old top moves into memory on a push
   assign wr_en = cmd.push && !cmd.clear && (count_ff != '0);
   assign wr_sum = count_ff - COUNT_W'(1);
   assign wr_ptr = wr_sum[ADDR_W-1:0];
   assign rd_sum = count_in - COUNT_W'(2);
   assign rd_ptr = rd_sum[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr] <= top_ff;
      end
   end

   // second entry from the top, with bypass of the entry being written
   always_ff @(posedge clock) begin
      if (wr_en) begin
         next_ff <= top_ff;
      end else begin
         next_ff <= mem[rd_ptr];
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.count = count_ff;
   assign status.top = top_ff;
   assign status.next = next_ff;

endmodule

// ===== hdl/i2p_seq.sv =====
// sequencer: decodes each character, drives stack pops and pushes, holds the response register
module i2p_seq #(
   parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   i2p_req_if.sink                 req_chan,
   i2p_rsp_if.source               rsp_chan,
   output i2p_pkg::stk_cmd_type     stk_cmd,
   input  i2p_pkg::stk_status_type  stk_status
);
   import i2p_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EMIT = 3'd1;
   localparam logic [2:0] ST_CLOSE = 3'd2;
   localparam logic [2:0] ST_OPER = 3'd3;
   localparam logic [2:0] ST_FLUSH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [STATUS_W-1:0] err_ff, err_in;
   logic [SYM_W-1:0] sym_ff, sym_in;
   logic [CODE_W-1:0] op_ff, op_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic can_emit;
   logic emit;
   rsp_payload_type emit_data;
   logic stack_full;
   logic two_or_more;

   assign can_emit = !rsp_valid_ff || rsp_chan.ready;
   assign stack_full = stk_status.count >= COUNT_W'(STACK_DEPTH);
   assign two_or_more = stk_status.count >= COUNT_W'(2);
   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      err_in = err_ff;
      sym_in = sym_ff;
      op_in = op_ff;
      stk_cmd = '0;
      emit = 1'b0;
      emit_data.out_symbol = CHAR_NUL;
      emit_data.symbol_valid = 1'b1;
      emit_data.last_of_run = 1'b0;
      emit_data.expression_done = 1'b0;
      emit_data.status = err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               sym_in = req_chan.symbol;
               op_in = op_code(req_chan.symbol);
               if (req_chan.command) begin
                  state_in = ST_FLUSH;
               end else if (err_ff == STATUS_OK) begin
                  priority if (is_operand(req_chan.symbol)) begin
                     state_in = ST_EMIT;
                  end else if (req_chan.symbol == CHAR_LPAREN) begin
                     if (stack_full) begin
                        err_in = STATUS_OVERFLOW;
                     end else begin
                        stk_cmd.push = 1'b1;
                        stk_cmd.code = CODE_LPAREN;
                     end
                  end else if (req_chan.symbol == CHAR_RPAREN) begin
                     state_in = ST_CLOSE;
                  end else if (op_code(req_chan.symbol) != CODE_NONE) begin
                     state_in = ST_OPER;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (can_emit) begin
               emit = 1'b1;
               emit_data.out_symbol = sym_ff;
               emit_data.last_of_run = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CLOSE: begin
            if (stk_status.count == '0) begin
               err_in = STATUS_UNMATCHED;
               state_in = ST_IDLE;
            end else if (stk_status.top == CODE_LPAREN) begin
               stk_cmd.pop = 1'b1;
               state_in = ST_IDLE;
            end else if (can_emit) begin
               emit = 1'b1;
               emit_data.out_symbol = code_char(stk_status.top);
               emit_data.last_of_run = !two_or_more || (stk_status.next == CODE_LPAREN);
               stk_cmd.pop = 1'b1;
            end
         end
         ST_OPER: begin
            if ((stk_status.count != '0) && pops_before(op_ff, stk_status.top)) begin
               if (can_emit) begin
                  emit = 1'b1;
                  emit_data.out_symbol = code_char(stk_status.top);
                  emit_data.last_of_run = !(two_or_more && pops_before(op_ff, stk_status.next));
                  stk_cmd.pop = 1'b1;
               end
            end else begin
               if (stack_full) begin
                  err_in = STATUS_OVERFLOW;
               end else begin
                  stk_cmd.push = 1'b1;
                  stk_cmd.code = op_ff;
               end
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (can_emit) begin
               emit = 1'b1;
               if (stk_status.count != '0) begin
                  emit_data.out_symbol = code_char(stk_status.top);
                  stk_cmd.pop = 1'b1;
               end else begin
                  emit_data.symbol_valid = 1'b0;
                  emit_data.last_of_run = 1'b1;
                  emit_data.expression_done = 1'b1;
                  stk_cmd.clear = 1'b1;
                  err_in = STATUS_OK;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in = emit_data;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         err_ff <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
      op_ff <= op_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.out_symbol = rsp_ff.out_symbol;
   assign rsp_chan.symbol_valid = rsp_ff.symbol_valid;
   assign rsp_chan.last_of_run = rsp_ff.last_of_run;
   assign rsp_chan.expression_done = rsp_ff.expression_done;
   assign rsp_chan.status = rsp_ff.status;

endmodule

// ===== hdl/i2p_checker.sv =====
// port-level checks for the infix to postfix converter, bound to the top level
module i2p_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_command,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_symbol,
   input logic       rsp_symbol_valid,
   input logic       rsp_last_of_run,
   input logic       rsp_expression_done,
   input logic [1:0] rsp_status
);

   // stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_symbol) &&
      $stable(rsp_symbol_valid) && $stable(rsp_last_of_run) &&
      $stable(rsp_expression_done) && $stable(rsp_status))
      else $error("response changed while stalled");

   // done response is closing and carries no character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_expression_done |->
      rsp_last_of_run && !rsp_symbol_valid && rsp_out_symbol == 8'd0)
      else $error("malformed done response");

   // only the done response lacks a character, and characters are never nul
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_expression_done |-> rsp_symbol_valid && rsp_out_symbol != 8'd0)
      else $error("character response without a character");

   // an end command always keeps the block busy for at least the done response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command |=> !req_ready)
      else $error("ready after end command");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .req_command(req_chan.command),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_out_symbol(rsp_chan.out_symbol),
   .rsp_symbol_valid(rsp_chan.symbol_valid),
   .rsp_last_of_run(rsp_chan.last_of_run),
   .rsp_expression_done(rsp_chan.expression_done),
   .rsp_status(rsp_chan.status)
);

// ===== bench/tb_top.sv =====
// self-checking testbench for the shunting-yard infix to postfix converter
`timescale 1ns / 1ps

module tb_top;
   import i2p_pkg::*;

   localparam int DEPTH = STACK_DEPTH_DEFAULT;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int TARGET_ITEMS = 370;
   localparam int MAX_REPORTS = 10;

   localparam logic [SYM_W-1:0] OP_CHARS [5] = '{CHAR_PLUS, CHAR_MINUS, CHAR_MUL,
                                                CHAR_DIV, CHAR_POW};
   localparam logic [SYM_W-1:0] CHAR_SPACE = 8'h20;

   class postfix_scoreboard;
      rsp_payload_type expected_q[$];
      rsp_payload_type run_q[$];
      logic [CODE_W-1:0] op_stack[DEPTH];
      int stack_level;
      logic [STATUS_W-1:0] sticky_err;
      int failures;

      function new();
         stack_level = 0;
         sticky_err = STATUS_OK;
         failures = 0;
      endfunction

      function logic [SYM_W-1:0] symbol_of(logic [CODE_W-1:0] code);
         case (code)
            CODE_PLUS:   return CHAR_PLUS;
            CODE_MINUS:  return CHAR_MINUS;
            CODE_MUL:    return CHAR_MUL;
            CODE_DIV:    return CHAR_DIV;
            CODE_POW:    return CHAR_POW;
            default:     return CHAR_LPAREN;
         endcase
      endfunction

      function int rank_of(logic [CODE_W-1:0] code);
         case (code)
            CODE_PLUS, CODE_MINUS: return 1;
            CODE_MUL, CODE_DIV:    return 2;
            CODE_POW:              return 3;
            default:               return 0;
         endcase
      endfunction

      function void emit(logic [SYM_W-1:0] sym, logic valid, logic done);
         rsp_payload_type item;
         item.out_symbol = sym;
         item.symbol_valid = valid;
         item.last_of_run = 1'b0;
         item.expression_done = done;
         item.status = sticky_err;
         run_q.push_back(item);
      endfunction

      function void pop_emit();
         stack_level--;
         emit(symbol_of(op_stack[stack_level]), 1'b1, 1'b0);
      endfunction

      function void push_code(logic [CODE_W-1:0] code);
         if (stack_level >= DEPTH) begin
            sticky_err = STATUS_OVERFLOW;
         end else begin
            op_stack[stack_level] = code;
            stack_level++;
         end
      endfunction

      function void note_request(logic cmd, logic [SYM_W-1:0] sym);
         logic [CODE_W-1:0] code;
         bit is_op;
         run_q.delete();
         if (cmd) begin
            while (stack_level > 0) pop_emit();
            emit(CHAR_NUL, 1'b0, 1'b1);
            sticky_err = STATUS_OK;
         end else if (sticky_err != STATUS_OK) begin
            // discarded until the end command
         end else if ((sym >= CHAR_LOWER_A && sym <= CHAR_LOWER_Z) ||
                      (sym >= CHAR_UPPER_A && sym <= CHAR_UPPER_Z) ||
                      (sym >= CHAR_ZERO && sym <= CHAR_NINE)) begin
            emit(sym, 1'b1, 1'b0);
         end else if (sym == CHAR_LPAREN) begin
            push_code(CODE_LPAREN);
         end else if (sym == CHAR_RPAREN) begin
            while (stack_level > 0 && op_stack[stack_level-1] != CODE_LPAREN) pop_emit();
            if (stack_level == 0) sticky_err = STATUS_UNMATCHED;
            else stack_level--;
         end else begin
            is_op = 1'b1;
            code = CODE_NONE;
            case (sym)
               CHAR_PLUS:  code = CODE_PLUS;
               CHAR_MINUS: code = CODE_MINUS;
               CHAR_MUL:   code = CODE_MUL;
               CHAR_DIV:   code = CODE_DIV;
               CHAR_POW:   code = CODE_POW;
               default:    is_op = 1'b0;
            endcase
            if (is_op) begin
               // right-associative power leaves equal rank on the stack
               while (stack_level > 0 && op_stack[stack_level-1] != CODE_LPAREN &&
                      (rank_of(code) < rank_of(op_stack[stack_level-1]) ||
                       (rank_of(code) == rank_of(op_stack[stack_level-1]) &&
                        code != CODE_POW)))
                  pop_emit();
               push_code(code);
            end
         end
         if (run_q.size() > 0) run_q[run_q.size()-1].last_of_run = 1'b1;
         foreach (run_q[i]) expected_q.push_back(run_q[i]);
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected response: sym %h valid %b last %b done %b status %0d",
                        got.out_symbol, got.symbol_valid, got.last_of_run,
                        got.expression_done, got.status);
            return;
         end
         want = expected_q.pop_front();
         if (got.out_symbol !== want.out_symbol || got.symbol_valid !== want.symbol_valid ||
             got.last_of_run !== want.last_of_run ||
             got.expression_done !== want.expression_done || got.status !== want.status) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("mismatch: expected sym %h valid %b last %b done %b status %0d,",
                        want.out_symbol, want.symbol_valid, want.last_of_run,
                        want.expression_done, want.status,
                        " got sym %h valid %b last %b done %b status %0d",
                        got.out_symbol, got.symbol_valid, got.last_of_run,
                        got.expression_done, got.status);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   i2p_req_if req_chan ();
   i2p_rsp_if rsp_chan ();

   infix_to_postfix_converter #(
      .STACK_DEPTH (DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   postfix_scoreboard sb;
   logic [SYM_W-1:0] infix_q[$];
   bit req_busy = 1'b0;
   bit rsp_busy = 1'b0;
   int rsp_hold = 0;
   int sent_items = 0;
   int stall_cycles = 0;

   always #5 clock = ~clock;

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic send_item(logic cmd, logic [SYM_W-1:0] sym);
      int gap;
      gap = req_busy ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.command <= cmd;
      req_chan.symbol <= sym;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_request(cmd, sym);
      sent_items++;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() > 0);
   endtask

   function automatic logic [SYM_W-1:0] random_operand();
      int idx;
      idx = $urandom_range(0, 61);
      if (idx < 26) return 8'(CHAR_LOWER_A + idx);
      if (idx < 52) return 8'(CHAR_UPPER_A + (idx - 26));
      return 8'(CHAR_ZERO + (idx - 52));
   endfunction

   task automatic gen_expr(int depth);
      int terms;
      terms = $urandom_range(1, 4);
      for (int i = 0; i < terms; i++) begin
         if (i > 0) infix_q.push_back(OP_CHARS[3'($urandom_range(0, 4))]);
         if (depth > 0 && $urandom_range(0, 2) == 0) begin
            infix_q.push_back(CHAR_LPAREN);
            gen_expr(depth - 1);
            infix_q.push_back(CHAR_RPAREN);
         end else begin
            infix_q.push_back(random_operand());
         end
      end
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) infix_q.push_back(s[i]);
   endtask

   task automatic send_expression(bit sprinkle);
      foreach (infix_q[i]) begin
         if (sprinkle && $urandom_range(0, 15) == 0)
            send_item(1'b0, $urandom_range(0, 1) ? CHAR_SPACE : 8'($urandom_range(0, 255)));
         send_item(1'b0, infix_q[i]);
      end
      send_item(1'b1, 8'($urandom_range(0, 255)));
      infix_q.delete();
   endtask

   initial begin
      int kind;
      int iter;
      int n;
      rsp_payload_type got;

      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.command <= 1'b0;
      req_chan.symbol <= '0;
      rsp_chan.ready <= 1'b0;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      fork
         forever begin
            int gap;
            if (rsp_hold > 0) gap = rsp_hold;
            else gap = rsp_busy ? $urandom_range(0, 19) : 0;
            rsp_hold = 0;
            if (gap > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_chan.ready <= 1'b1;
            do @(posedge clock); while (rsp_chan.valid !== 1'b1);
            got.out_symbol = rsp_chan.out_symbol;
            got.symbol_valid = rsp_chan.symbol_valid;
            got.last_of_run = rsp_chan.last_of_run;
            got.expression_done = rsp_chan.expression_done;
            got.status = rsp_chan.status;
            sb.check_response(got);
         end
      join_none

      // directed: field extremes, every operator, ignored characters
      push_text("A*(z-0)/9");
      send_expression(1'b0);
      push_text("a^ b^c+Z");
      infix_q.insert(3, 8'hFF);
      infix_q.insert(0, 8'h00);
      send_expression(1'b0);
      // unmatched open paren flushed as a character
      push_text("(a");
      send_expression(1'b0);
      // unmatched close paren, later symbols discarded
      push_text(")b");
      send_expression(1'b0);

      iter = 0;
      while (sent_items < TARGET_ITEMS) begin
         req_busy = $urandom_range(0, 3) != 0;
         rsp_busy = $urandom_range(0, 3) != 0;
         kind = (iter == 0) ? 95 : $urandom_range(0, 99);
         if (iter == 2) begin
            rsp_hold = HOLD_CYCLES;
            req_busy = 1'b0;
            kind = 0;
         end
         if (iter == 5 || $urandom_range(0, 9) == 0) wait_drained();
         if (kind < 70) begin
            gen_expr($urandom_range(0, 3));
            if (iter == 2) gen_expr(3);
            send_expression(1'b1);
         end else if (kind < 80) begin
            gen_expr($urandom_range(1, 3));
            case ($urandom_range(0, 2))
               0: infix_q.insert($urandom_range(0, infix_q.size()), CHAR_RPAREN);
               1: infix_q.insert($urandom_range(0, infix_q.size()), CHAR_LPAREN);
               default: infix_q.delete($urandom_range(0, infix_q.size() - 1));
            endcase
            send_expression(1'b1);
         end else if (kind < 90) begin
            n = $urandom_range(1, 8);
            repeat (n) send_item($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
            send_item(1'b1, 8'($urandom_range(0, 255)));
         end else begin
            // deep nesting or a long power chain, near or past the stack limit
            n = (iter == 0) ? DEPTH + 1 : $urandom_range(DEPTH - 2, DEPTH + 8);
            if (iter == 0 || $urandom_range(0, 1)) begin
               repeat (n) infix_q.push_back(CHAR_LPAREN);
               infix_q.push_back(random_operand());
            end else begin
               repeat (n) begin
                  infix_q.push_back(random_operand());
                  infix_q.push_back(CHAR_POW);
               end
               infix_q.push_back(random_operand());
            end
            repeat ($urandom_range(0, 3)) infix_q.push_back(CHAR_RPAREN);
            send_expression(1'b0);
         end
         iter++;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
